### rtl/core/grw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the grid ray walk block.
// No dependencies; every other file of the block imports this package.
package grw_pkg;

	// Geometry of the wall store: a square of STORE_SIDE by STORE_SIDE cells.
	localparam int STORE_SIDE    = 16;
	localparam int COORD_W       = 4;
	localparam int ADDR_W        = 2 * COORD_W;
	localparam int DIM_W         = 5;
	localparam int WALL_W        = 4;
	localparam int MAG_W         = 16;
	localparam int ERR_W         = 18;
	localparam int GRID_SIZE_DEF = 16;

	// Bit positions of the walls inside one cell entry.
	localparam int WB_UP    = 0;
	localparam int WB_DOWN  = 1;
	localparam int WB_LEFT  = 2;
	localparam int WB_RIGHT = 3;

	// Operation codes of an input item.
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_RAY   = 1'b1;

	// Register indexes on the configuration port.
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// Input item.
	typedef struct packed {
		logic                    opcode;
		logic [COORD_W-1:0]      cell_x;
		logic [COORD_W-1:0]      cell_y;
		logic [WALL_W-1:0]       wall_bits;
		logic signed [MAG_W-1:0] dir_x;
		logic signed [MAG_W-1:0] dir_y;
	} grw_in_t;

	// Result item.
	typedef struct packed {
		logic [COORD_W-1:0] out_x;
		logic [COORD_W-1:0] out_y;
		logic               last;
	} grw_out_t;

	// Effective grid limits seen by the walker.
	typedef struct packed {
		logic [DIM_W-1:0] lim_x;
		logic [DIM_W-1:0] lim_y;
	} grw_lim_t;

	// Cell emission from the walker to the output stage.
	typedef struct packed {
		logic               push;
		logic               flush;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} grw_emit_t;

	// Walker sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_MAJ,
		S_MIN,
		S_CRN,
		S_CRN2,
		S_POS,
		S_FIN
	} grw_state_t;

endpackage

### rtl/core/grw_wall_mem.sv
`timescale 1ns / 1ps
// Wall store: 256 cells of four wall bits, one write and one registered read port.
// Depends on grw_pkg. Per-cell valid flags make unwritten cells read as no walls.
module grw_wall_mem (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        we,
	input  logic [grw_pkg::ADDR_W-1:0]  waddr,
	input  logic [grw_pkg::WALL_W-1:0]  wdata,
	input  logic [grw_pkg::ADDR_W-1:0]  raddr,
	output logic [grw_pkg::WALL_W-1:0]  rdata
);
	import grw_pkg::*;

	localparam int DEPTH = STORE_SIDE * STORE_SIDE;

	logic [WALL_W-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	logic [WALL_W-1:0] rdata_q;

	// Storage array, written at one address per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Valid flags are cleared by reset so the store starts with no walls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	// Registered read; a cell never written reads as zero.
	always_ff @(posedge clk) begin
		rdata_q <= valid_q[raddr] ? mem_q[raddr] : '0;
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/grw_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration registers (grid width and height) behind an APB-style port.
// Depends on grw_pkg. Also derives the clamped grid limits used by the walker.
module grw_cfg_regs #(
	parameter int GRID_SIZE = grw_pkg::GRID_SIZE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output grw_pkg::grw_lim_t lim
);
	import grw_pkg::*;

	localparam int               LIM   = (GRID_SIZE < STORE_SIDE) ? GRID_SIZE : STORE_SIDE;
	localparam logic [DIM_W-1:0] LIM_V = DIM_W'(LIM);

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;

	// Zero reads as one cell, values above the limit saturate.
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
		logic [DIM_W-1:0] v;
		if (r == '0) begin
			v = DIM_W'(1);
		end else if (r > LIM_V) begin
			v = LIM_V;
		end else begin
			v = r;
		end
		return v;
	endfunction

	// Register writes complete in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(1);
			height_q <= DIM_W'(1);
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
				REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Read data returns the raw register contents.
	always_comb begin
		case (paddr[2])
			REG_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, width_q};
			REG_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, height_q};
			default:    prdata = '0;
		endcase
	end

	assign pready    = 1'b1;
	assign lim.lim_x = eff_dim(width_q);
	assign lim.lim_y = eff_dim(height_q);

endmodule

### rtl/core/grw_walker.sv
`timescale 1ns / 1ps
// Ray walk sequencer: decodes items, writes walls, and steps the Bresenham walk
// against the wall store one read per cycle. Depends on grw_pkg.
module grw_walker #(
	parameter int GRID_SIZE = grw_pkg::GRID_SIZE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  grw_pkg::grw_in_t            item,
	input  grw_pkg::grw_lim_t           lim,
	output logic                        busy,
	output logic                        we,
	output logic [grw_pkg::ADDR_W-1:0]  waddr,
	output logic [grw_pkg::WALL_W-1:0]  wdata,
	output logic [grw_pkg::ADDR_W-1:0]  raddr,
	input  logic [grw_pkg::WALL_W-1:0]  rdata,
	output grw_pkg::grw_emit_t          emit
);
	import grw_pkg::*;

	localparam logic [DIM_W-1:0] GS_V = DIM_W'(GRID_SIZE);

	grw_state_t         state_q, state_d;
	logic [COORD_W-1:0] px_q, px_d, py_q, py_d;
	logic               negx_q, negx_d, negy_q, negy_d, ymaj_q, ymaj_d;
	logic [MAG_W-1:0]   maga_q, maga_d, magb_q, magb_d;
	logic [ERR_W-1:0]   e_q, e_d, ep_q, ep_d;

	logic [MAG_W-1:0]   magx, magy;
	logic [ERR_W-1:0]   thr, e_add, e_sub, s_sum;
	logic [COORD_W-1:0] pa, pb, pa_next, pb_next, x_back, y_back;
	logic [DIM_W-1:0]   lim_a, lim_b;
	logic               nega, negb, a_block, b_block;
	logic               wall_x, wall_y, wall_a, wall_b;
	logic               in_grid, in_lim;

	// Magnitude of a Q1.14 component; the most negative code gives 32768.
	function automatic logic [MAG_W-1:0] mag_of(input logic signed [MAG_W-1:0] d);
		logic [MAG_W:0] ext;
		ext = {d[MAG_W-1], d};
		if (d[MAG_W-1]) begin
			ext = -ext;
		end
		return ext[MAG_W-1:0];
	endfunction

	// Axis selection and step arithmetic shared by the states.
	always_comb begin
		magx    = mag_of(item.dir_x);
		magy    = mag_of(item.dir_y);
		thr     = {1'b0, maga_q, 1'b0};
		e_add   = e_q + {1'b0, magb_q, 1'b0};
		e_sub   = e_q - thr;
		s_sum   = e_q + ep_q;
		pa      = ymaj_q ? py_q : px_q;
		pb      = ymaj_q ? px_q : py_q;
		nega    = ymaj_q ? negy_q : negx_q;
		negb    = ymaj_q ? negx_q : negy_q;
		lim_a   = ymaj_q ? lim.lim_y : lim.lim_x;
		lim_b   = ymaj_q ? lim.lim_x : lim.lim_y;
		pa_next = nega ? pa - COORD_W'(1) : pa + COORD_W'(1);
		pb_next = negb ? pb - COORD_W'(1) : pb + COORD_W'(1);
		a_block = nega ? (pa == '0) : (({1'b0, pa} + DIM_W'(1)) >= lim_a);
		b_block = negb ? (pb == '0) : (({1'b0, pb} + DIM_W'(1)) >= lim_b);
		x_back  = negx_q ? px_q + COORD_W'(1) : px_q - COORD_W'(1);
		y_back  = negy_q ? py_q + COORD_W'(1) : py_q - COORD_W'(1);
		wall_x  = negx_q ? rdata[WB_LEFT] : rdata[WB_RIGHT];
		wall_y  = negy_q ? rdata[WB_UP] : rdata[WB_DOWN];
		wall_a  = ymaj_q ? wall_y : wall_x;
		wall_b  = ymaj_q ? wall_x : wall_y;
		in_grid = ({1'b0, item.cell_x} < GS_V) && ({1'b0, item.cell_y} < GS_V);
		in_lim  = ({1'b0, item.cell_x} < lim.lim_x) && ({1'b0, item.cell_y} < lim.lim_y);
	end

	// Next state, register updates, memory access and cell emission.
	always_comb begin
		state_d = state_q;
		px_d    = px_q;
		py_d    = py_q;
		negx_d  = negx_q;
		negy_d  = negy_q;
		ymaj_d  = ymaj_q;
		maga_d  = maga_q;
		magb_d  = magb_q;
		e_d     = e_q;
		ep_d    = ep_q;
		we      = 1'b0;
		waddr   = {item.cell_y, item.cell_x};
		wdata   = item.wall_bits;
		emit    = '0;

		case (state_q)
			S_IDLE: begin
				px_d   = item.cell_x;
				py_d   = item.cell_y;
				negx_d = item.dir_x[MAG_W-1];
				negy_d = item.dir_y[MAG_W-1];
				ymaj_d = magy > magx;
				maga_d = (magy > magx) ? magy : magx;
				magb_d = (magy > magx) ? magx : magy;
				e_d    = {2'b00, ((magy > magx) ? magy : magx)};
				ep_d   = {2'b00, ((magy > magx) ? magy : magx)};
				if (start) begin
					if (item.opcode == OP_WRITE) begin
						we = in_grid;
					end else if (in_lim) begin
						emit.push = 1'b1;
						emit.x    = item.cell_x;
						emit.y    = item.cell_y;
						state_d   = (magx == '0 && magy == '0) ? S_FIN : S_MAJ;
					end
				end
			end
			// Wall of the current cell is in; take one major step.
			S_MAJ: begin
				if (wall_a || a_block) begin
					state_d = S_FIN;
				end else begin
					if (ymaj_q) begin
						py_d = pa_next;
					end else begin
						px_d = pa_next;
					end
					e_d = e_add;
					if (e_add > thr) begin
						state_d = S_MIN;
					end else begin
						ep_d      = e_add;
						emit.push = 1'b1;
						emit.x    = ymaj_q ? px_q : pa_next;
						emit.y    = ymaj_q ? pa_next : py_q;
					end
				end
			end
			// Error passed the threshold; take the minor step.
			S_MIN: begin
				if (wall_b || b_block) begin
					state_d = S_FIN;
				end else begin
					if (ymaj_q) begin
						px_d = pb_next;
					end else begin
						py_d = pb_next;
					end
					e_d     = e_sub;
					state_d = S_CRN;
				end
			end
			// Diagonal cell walls are in; pick the supercover corner.
			S_CRN: begin
				if (s_sum < thr) begin
					state_d = S_POS;
					if (!wall_b) begin
						emit.push = 1'b1;
						emit.x    = ymaj_q ? x_back : px_q;
						emit.y    = ymaj_q ? py_q : y_back;
					end
				end else if (s_sum > thr) begin
					state_d = S_POS;
					if (!wall_a) begin
						emit.push = 1'b1;
						emit.x    = ymaj_q ? px_q : x_back;
						emit.y    = ymaj_q ? y_back : py_q;
					end
				end else begin
					// The ray passes exactly through the corner: both neighbors.
					state_d = S_CRN2;
					if (!wall_y) begin
						emit.push = 1'b1;
						emit.x    = px_q;
						emit.y    = y_back;
					end
				end
			end
			S_CRN2: begin
				state_d = S_POS;
				if (!wall_x) begin
					emit.push = 1'b1;
					emit.x    = x_back;
					emit.y    = py_q;
				end
			end
			S_POS: begin
				ep_d      = e_q;
				emit.push = 1'b1;
				emit.x    = px_q;
				emit.y    = py_q;
				state_d   = S_MAJ;
			end
			S_FIN: begin
				emit.flush = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// The read port always follows the cell the walk stands on next.
		raddr = {py_d, px_d};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Walk registers carry payload only.
	always_ff @(posedge clk) begin
		px_q   <= px_d;
		py_q   <= py_d;
		negx_q <= negx_d;
		negy_q <= negy_d;
		ymaj_q <= ymaj_d;
		maga_q <= maga_d;
		magb_q <= magb_d;
		e_q    <= e_d;
		ep_q   <= ep_d;
	end

	assign busy = (state_q != S_IDLE);

endmodule

### rtl/core/grw_out_stage.sv
`timescale 1ns / 1ps
// Output stage: holds the latest cell back by one so the final cell of a ray
// can be flagged, and drives the registered result strobe. Depends on grw_pkg.
module grw_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  grw_pkg::grw_emit_t emit,
	output logic               result_valid,
	output grw_pkg::grw_out_t  result
);
	import grw_pkg::*;

	logic               pend_valid_q;
	logic [COORD_W-1:0] pend_x_q, pend_y_q;
	logic               out_valid_q;
	grw_out_t           out_q;

	// Control flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			out_valid_q <= (emit.push && pend_valid_q) || (emit.flush && pend_valid_q);
			if (emit.push) begin
				pend_valid_q <= 1'b1;
			end else if (emit.flush) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// A new cell pushes the held one out; a flush sends it out as the last.
	always_ff @(posedge clk) begin
		if (emit.push || emit.flush) begin
			out_q.out_x <= pend_x_q;
			out_q.out_y <= pend_y_q;
			out_q.last  <= emit.flush;
		end
		if (emit.push) begin
			pend_x_q <= emit.x;
			pend_y_q <= emit.y;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

### rtl/core/grid_ray_walk_with_walls_top.sv
`timescale 1ns / 1ps
// Top level of the grid ray walk block.
// Depends on grw_pkg, grw_cfg_regs, grw_walker, grw_wall_mem and grw_out_stage.
//
// Usage:
//   An item is taken at a rising edge with start high and busy low. Opcode
//   write stores the four wall bits of one cell, gives no result and leaves
//   busy low. Opcode ray walks from the start cell and emits every reached
//   cell on result, one cycle each, marked by result_valid; the final cell
//   of the ray carries last.
//   A ray keeps busy high through its straight and diagonal steps (both
//   corner cells are checked on an exact corner hit) and while it finds the
//   stop and finishes. Each step waits on the single read port of the wall
//   memory, whose read data are registered.
//   Each result shows in the cycle after the next cell is found; a ray that
//   stops in its start cell gives that cell as its one result. The final
//   result shows in the first cycle with busy low, when the next item may
//   already be taken. Results cannot be held off; the receiver takes each one
//   as it shows. Width and height sit at byte addresses 0 and 4. The user must
//   see they are written only idle; the block itself does not enforce this.
//   Reset clears all walls at once (no sweep), sets width and height to one
//   and returns the sequencer to idle.
module grid_ray_walk_with_walls_top #(
	parameter int GRID_SIZE = grw_pkg::GRID_SIZE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  grw_pkg::grw_in_t  item,
	output logic              result_valid,
	output grw_pkg::grw_out_t result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import grw_pkg::*;

	grw_lim_t          lim;
	grw_emit_t         emit;
	logic              we;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [WALL_W-1:0] wdata, rdata;

	grw_cfg_regs #(
		.GRID_SIZE(GRID_SIZE)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.lim    (lim)
	);

	grw_walker #(
		.GRID_SIZE(GRID_SIZE)
	) u_walker (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.item  (item),
		.lim   (lim),
		.busy  (busy),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata),
		.emit  (emit)
	);

	grw_wall_mem u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	grw_out_stage u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.emit        (emit),
		.result_valid(result_valid),
		.result      (result)
	);

endmodule

### rtl/core/grw_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the grid ray walk block, bound to the top level.
// Depends on grw_pkg and grid_ray_walk_with_walls_top.
module grw_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input grw_pkg::grw_in_t  item,
	input logic              result_valid,
	input grw_pkg::grw_out_t result
);
	import grw_pkg::*;

	// A wall write does not raise busy.
	a_write_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.opcode == OP_WRITE |=> !busy)
		else $error("busy raised by a wall write");

	// Busy only rises after an accepted item.
	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without an item");

	// A result that is not the last one arrives while the ray is still walking.
	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |-> busy)
		else $error("ray ended without a last result");

	// The last result shows once the walk has finished.
	a_last_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |-> !busy)
		else $error("last result while still walking");

endmodule

bind grid_ray_walk_with_walls_top grw_checker u_chk (.*);

### verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for grid_ray_walk_with_walls_top: walls are written and rays
// are traced, and every emitted cell is compared with an in-bench model of the walk or a directed expectation.
// Depends on grw_pkg and the RTL of the block only.
module tb;
	import grw_pkg::*;

	localparam int MAX_CELLS   = 46;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 100;
	localparam int N_PHASES    = 5;
	localparam int PHASE_W [N_PHASES]     = '{16, 0, 31, 7, 16};
	localparam int PHASE_H [N_PHASES]     = '{16, 0, 12, 16, 16};
	localparam int PHASE_ITEMS [N_PHASES] = '{90, 40, 90, 90, 90};

	// How a stimulus row is checked, or whether it changes the grid size.
	typedef enum logic [1:0] {
		RK_PREDICT,
		RK_ONE_CELL,
		RK_NO_RESULT,
		RK_CONFIG
	} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		grw_in_t          cmd;
		logic [DIM_W-1:0] cfg_w;
		logic [DIM_W-1:0] cfg_h;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	grw_in_t     item;
	logic        result_valid;
	grw_out_t    result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Model state: wall copy, grid size registers, cells still due from the block.
	logic [WALL_W-1:0] wall_copy [0:STORE_SIDE*STORE_SIDE-1];
	logic [DIM_W-1:0]  grid_w;
	logic [DIM_W-1:0]  grid_h;
	grw_out_t          ray_cells [$];
	grw_out_t          due_cells [$];
	row_kind_t         row_kind;
	bit                gaps_on;
	int                err_count;
	int                stall_cycles;
	stim_row_t         stim_rows [$];

	grid_ray_walk_with_walls_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Prints one line per mismatch and counts it.
	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] mismatch: %s: got %0d, expected %0d", $time, what, got, want);
		err_count++;
	endtask

	// Register value as the walker sees it: zero means one, large values saturate.
	function automatic int eff_dim(input logic [DIM_W-1:0] r);
		int lim;
		lim = GRID_SIZE_DEF < STORE_SIDE ? GRID_SIZE_DEF : STORE_SIDE;
		if (r == 0) return 1;
		if (int'(r) > lim) return lim;
		return int'(r);
	endfunction

	function automatic void add_cell(input int x, input int y);
		grw_out_t c;
		if (ray_cells.size() >= MAX_CELLS) return;
		c.out_x = x[COORD_W-1:0];
		c.out_y = y[COORD_W-1:0];
		c.last = 1'b0;
		ray_cells.insert(ray_cells.size(), c);
	endfunction

	// Applies one item to the model; the cells a ray reaches are left in ray_cells.
	function automatic void walk_item(input grw_in_t it);
		int lim [2];
		int pos [2];
		int mag [2];
		int st [2];
		int wb [2];
		int dv [2];
		int qp [2];
		int try_ax [2];
		int ax, bx, thr, e, ep, s, np, k, n_try;
		logic [WALL_W-1:0] c;
		ray_cells.delete();
		if (it.opcode == OP_WRITE) begin
			if (int'(it.cell_x) < GRID_SIZE_DEF && int'(it.cell_y) < GRID_SIZE_DEF)
				wall_copy[int'(it.cell_y) * STORE_SIDE + int'(it.cell_x)] = it.wall_bits;
			return;
		end
		lim[0] = eff_dim(grid_w);
		lim[1] = eff_dim(grid_h);
		if (int'(it.cell_x) >= lim[0] || int'(it.cell_y) >= lim[1]) return;
		pos[0] = int'(it.cell_x);
		pos[1] = int'(it.cell_y);
		add_cell(pos[0], pos[1]);
		dv[0] = int'(it.dir_x);
		dv[1] = int'(it.dir_y);
		for (k = 0; k < 2; k++) begin
			mag[k] = dv[k] < 0 ? -dv[k] : dv[k];
			st[k] = dv[k] > 0 ? 1 : (dv[k] < 0 ? -1 : 0);
		end
		wb[0] = st[0] >= 0 ? WB_RIGHT : WB_LEFT;
		wb[1] = st[1] >= 0 ? WB_DOWN : WB_UP;
		if (mag[0] != 0 || mag[1] != 0) begin
			// The error is kept doubled so that the half-cell offset stays an integer.
			ax = mag[0] >= mag[1] ? 0 : 1;
			bx = 1 - ax;
			thr = 2 * mag[ax];
			e = mag[ax];
			ep = e;
			while (1) begin
				if (wall_copy[pos[1] * STORE_SIDE + pos[0]][wb[ax]]) break;
				np = pos[ax] + st[ax];
				if (np < 0 || np >= lim[ax]) break;
				pos[ax] = np;
				e += 2 * mag[bx];
				if (e > thr) begin
					if (wall_copy[pos[1] * STORE_SIDE + pos[0]][wb[bx]]) break;
					np = pos[bx] + st[bx];
					if (np < 0 || np >= lim[bx]) break;
					pos[bx] = np;
					e -= thr;
					c = wall_copy[pos[1] * STORE_SIDE + pos[0]];
					// Supercover: the corner lies on the side the line crossed; an
					// exact corner hit checks both neighbors, y first.
					s = e + ep;
					if (s < thr) begin
						try_ax[0] = bx;
						n_try = 1;
					end else if (s > thr) begin
						try_ax[0] = ax;
						n_try = 1;
					end else begin
						try_ax[0] = 1;
						try_ax[1] = 0;
						n_try = 2;
					end
					for (k = 0; k < n_try; k++) begin
						if (!c[wb[try_ax[k]]]) begin
							qp[0] = pos[0];
							qp[1] = pos[1];
							qp[try_ax[k]] -= st[try_ax[k]];
							if (qp[try_ax[k]] >= 0 && qp[try_ax[k]] < lim[try_ax[k]])
								add_cell(qp[0], qp[1]);
						end
					end
				end
				add_cell(pos[0], pos[1]);
				ep = e;
			end
		end
		if (ray_cells.size() > 0) ray_cells[ray_cells.size() - 1].last = 1'b1;
	endfunction

	// Result check, model update on accepted items and register writes, watchdog.
	always @(posedge clk) begin : track
		grw_out_t want;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (result_valid) begin
				moved = 1'b1;
				if (due_cells.size() == 0) begin
					report_mismatch("cell with nothing due, out_x", int'(result.out_x), -1);
				end else begin
					want = due_cells.pop_front();
					if (result.out_x !== want.out_x)
						report_mismatch("out_x", int'(result.out_x), int'(want.out_x));
					if (result.out_y !== want.out_y)
						report_mismatch("out_y", int'(result.out_y), int'(want.out_y));
					if (result.last !== want.last)
						report_mismatch("last", int'(result.last), int'(want.last));
				end
			end
			if (psel && penable && pwrite && pready) begin
				moved = 1'b1;
				if (paddr == {REG_WIDTH, 2'b00}) grid_w = pwdata[DIM_W-1:0];
				else if (paddr == {REG_HEIGHT, 2'b00}) grid_h = pwdata[DIM_W-1:0];
			end
			if (start && !busy) begin
				moved = 1'b1;
				walk_item(item);
				case (row_kind)
					RK_PREDICT: foreach (ray_cells[i]) due_cells.insert(due_cells.size(), ray_cells[i]);
					RK_ONE_CELL: begin
						want.out_x = item.cell_x;
						want.out_y = item.cell_y;
						want.last = 1'b1;
						due_cells.insert(due_cells.size(), want);
					end
					default: ;
				endcase
			end
			stall_cycles = moved ? 0 : stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Offers one item, with random gaps, until the block takes it.
	task automatic send_item(input grw_in_t it, input row_kind_t kind);
		bit taken;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			if (gaps_on && $urandom_range(99) < 7) begin
				start = 1'b0;
			end else begin
				start = 1'b1;
				item = it;
				row_kind = kind;
			end
			@(posedge clk);
			taken = start && !busy;
		end
	endtask

	// Lets the block drain completely before its registers change.
	task automatic settle();
		@(negedge clk);
		start = 1'b0;
		while (due_cells.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		while (busy) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] val);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	function automatic stim_row_t ray_row(input row_kind_t kind, input int x, input int y,
			input int dx, input int dy);
		stim_row_t r;
		r.kind = kind;
		r.cmd.opcode = OP_RAY;
		r.cmd.cell_x = x[COORD_W-1:0];
		r.cmd.cell_y = y[COORD_W-1:0];
		r.cmd.wall_bits = 4'hF;
		r.cmd.dir_x = dx[MAG_W-1:0];
		r.cmd.dir_y = dy[MAG_W-1:0];
		r.cfg_w = '0;
		r.cfg_h = '0;
		return r;
	endfunction

	function automatic stim_row_t wall_row(input int x, input int y, input int bits,
			input int dx, input int dy);
		stim_row_t r;
		r = ray_row(RK_NO_RESULT, x, y, dx, dy);
		r.cmd.opcode = OP_WRITE;
		r.cmd.wall_bits = bits[WALL_W-1:0];
		return r;
	endfunction

	function automatic stim_row_t size_row(input int w, input int h);
		stim_row_t r;
		r = ray_row(RK_CONFIG, 0, 0, 0, 0);
		r.cfg_w = w[DIM_W-1:0];
		r.cfg_h = h[DIM_W-1:0];
		return r;
	endfunction

	// Random item shaped for the current grid: sparse walls, starts mostly inside.
	function automatic grw_in_t rand_item();
		grw_in_t it;
		int m;
		int k;
		it.cell_x = COORD_W'($urandom);
		it.cell_y = COORD_W'($urandom);
		it.wall_bits = WALL_W'($urandom);
		it.dir_x = MAG_W'($urandom);
		it.dir_y = MAG_W'($urandom);
		if ($urandom_range(99) < 35) begin
			it.opcode = OP_WRITE;
			it.wall_bits = '0;
			for (k = 0; k < WALL_W; k++)
				if ($urandom_range(99) < 15) it.wall_bits[k] = 1'b1;
			return it;
		end
		it.opcode = OP_RAY;
		if ($urandom_range(9) != 0) begin
			it.cell_x = COORD_W'($urandom_range(eff_dim(grid_w) - 1));
			it.cell_y = COORD_W'($urandom_range(eff_dim(grid_h) - 1));
		end
		case ($urandom_range(7))
			0: ;
			1, 2: begin
				it.dir_x = MAG_W'($urandom_range(32768) - 16384);
				it.dir_y = MAG_W'($urandom_range(32768) - 16384);
			end
			3: begin
				it.dir_x = MAG_W'($urandom_range(32768) - 16384);
				it.dir_y = MAG_W'($urandom_range(32768) - 16384);
				if ($urandom_range(1)) it.dir_x = '0;
				else it.dir_y = '0;
			end
			4: begin
				m = int'($urandom_range(16384));
				it.dir_x = MAG_W'($urandom_range(1) ? m : -m);
				it.dir_y = MAG_W'($urandom_range(1) ? m : -m);
			end
			5: begin
				it.dir_x = MAG_W'($urandom_range(16) - 8);
				it.dir_y = MAG_W'($urandom_range(16) - 8);
			end
			6: begin
				if ($urandom_range(1)) it.dir_x = 16'sh8000;
				else it.dir_y = 16'sh8000;
			end
			default: begin
				it.dir_x = '0;
				it.dir_y = ($urandom_range(2) == 0) ? '0 :
					MAG_W'($urandom_range(32768) - 16384);
			end
		endcase
		return it;
	endfunction

	initial begin : stimulus
		int ph;
		logic [31:0] junk;
		start = 1'b0;
		item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		row_kind = RK_PREDICT;
		gaps_on = 1'b1;
		err_count = 0;
		stall_cycles = 0;
		grid_w = 1;
		grid_h = 1;
		foreach (wall_copy[i]) wall_copy[i] = '0;
		arst_n = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Directed rows: reset size first, then full grid, walls, odd sizes.
		stim_rows.insert(stim_rows.size(), ray_row(RK_ONE_CELL, 0, 0, 16384, 0));
		stim_rows.insert(stim_rows.size(), ray_row(RK_NO_RESULT, 1, 0, 16384, 0));
		stim_rows.insert(stim_rows.size(), ray_row(RK_NO_RESULT, 0, 5, 0, 16384));
		stim_rows.insert(stim_rows.size(), size_row(16, 16));
		stim_rows.insert(stim_rows.size(), ray_row(RK_ONE_CELL, 0, 0, 0, 0));
		stim_rows.insert(stim_rows.size(), ray_row(RK_ONE_CELL, 15, 15, 0, 0));
		stim_rows.insert(stim_rows.size(), ray_row(RK_PREDICT, 0, 0, 16384, 16384));
		stim_rows.insert(stim_rows.size(), ray_row(RK_PREDICT, 0, 0, 16384, 0));
		stim_rows.insert(stim_rows.size(), ray_row(RK_PREDICT, 15, 15, -32768, -32768));
		stim_rows.insert(stim_rows.size(), ray_row(RK_PREDICT, 15, 0, -16384, 8192));
		stim_rows.insert(stim_rows.size(), ray_row(RK_PREDICT, 0, 15, 3000, -16384));
		stim_rows.insert(stim_rows.size(), wall_row(5, 0, 1 << WB_RIGHT, 0, 0));
		stim_rows.insert(stim_rows.size(), ray_row(RK_PREDICT, 0, 0, 16384, 0));
		stim_rows.insert(stim_rows.size(), wall_row(3, 3, 15, 0, 0));
		stim_rows.insert(stim_rows.size(), ray_row(RK_ONE_CELL, 3, 3, 16384, 5000));
		stim_rows.insert(stim_rows.size(), wall_row(15, 15, 0, -1, -1));
		stim_rows.insert(stim_rows.size(), wall_row(7, 7, 6, -32768, 32767));
		stim_rows.insert(stim_rows.size(), ray_row(RK_PREDICT, 7, 7, -16384, 1));
		stim_rows.insert(stim_rows.size(), size_row(0, 31));
		stim_rows.insert(stim_rows.size(), ray_row(RK_PREDICT, 0, 0, 16384, 16384));
		stim_rows.insert(stim_rows.size(), ray_row(RK_PREDICT, 0, 8, 0, -16384));
		stim_rows.insert(stim_rows.size(), ray_row(RK_NO_RESULT, 1, 0, 0, 16384));
		stim_rows.insert(stim_rows.size(), size_row(5, 3));
		stim_rows.insert(stim_rows.size(), ray_row(RK_PREDICT, 4, 2, -16384, -10000));
		stim_rows.insert(stim_rows.size(), ray_row(RK_NO_RESULT, 5, 0, 16384, 0));
		stim_rows.insert(stim_rows.size(), ray_row(RK_NO_RESULT, 0, 3, 0, 16384));
		foreach (stim_rows[i]) begin
			if (stim_rows[i].kind == RK_CONFIG) begin
				settle();
				write_reg(REG_WIDTH, 32'(stim_rows[i].cfg_w));
				write_reg(REG_HEIGHT, 32'(stim_rows[i].cfg_h));
			end else begin
				send_item(stim_rows[i].cmd, stim_rows[i].kind);
			end
		end

		// Random phases; the third runs with no gaps, the last at a random size.
		for (ph = 0; ph < N_PHASES; ph++) begin
			settle();
			junk = (ph == N_PHASES - 1) ? ($urandom & 32'hFFFF_FFE0) : 32'd0;
			if (ph == N_PHASES - 1) begin
				write_reg(REG_WIDTH, junk | $urandom_range(31));
				write_reg(REG_HEIGHT, junk | $urandom_range(31));
			end else begin
				write_reg(REG_WIDTH, 32'(PHASE_W[ph]));
				write_reg(REG_HEIGHT, 32'(PHASE_H[ph]));
			end
			gaps_on = (ph != 2);
			repeat (PHASE_ITEMS[ph]) send_item(rand_item(), RK_PREDICT);
		end

		// Drain, then give late or extra cells time to show.
		@(negedge clk);
		start = 1'b0;
		while (due_cells.size() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		if (due_cells.size() != 0) report_mismatch("cells never emitted", 0, due_cells.size());
		if (err_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
